FILE: hw/rtl/esc_srs_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and constants of the ESC speed and reverse sequencer.
// Depends on nothing; every other file of the block imports it.
package esc_srs_pkg;

    localparam int DUTY_WIDTH_DEF = 16;
    localparam int CFG_ADDR_WIDTH = 5;
    localparam int STEP_WIDTH     = 7;
    localparam int MAG_WIDTH      = 7;
    localparam int SPD_EXT_WIDTH  = 10;

    localparam logic [31:0] DUTY_CEIL_RESET = 32'd65535;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = 7'd10;

    // Exact divide by 100 for any 32 bit unsigned value.
    localparam logic [31:0] RECIP_100       = 32'h51EB851F;
    localparam int          RECIP_100_SHIFT = 37;
    // Exact divide by 100 for values below 10000.
    localparam logic [12:0] RECIP_100_SMALL       = 13'd5243;
    localparam int          RECIP_100_SMALL_SHIFT = 19;

    localparam logic signed [SPD_EXT_WIDTH-1:0] SPEED_MAX       = 10'sd100;
    localparam logic signed [SPD_EXT_WIDTH-1:0] SPEED_MIN       = -10'sd100;
    localparam logic signed [SPD_EXT_WIDTH-1:0] BRAKE_FWD_SPEED = 10'sd50;
    localparam logic signed [SPD_EXT_WIDTH-1:0] REV_PROBE_SPEED = -10'sd20;
    localparam logic signed [SPD_EXT_WIDTH-1:0] SPEED_ZERO      = 10'sd0;

    typedef enum logic [2:0] {
        REG_DUTY_NEUTRAL   = 3'd0,
        REG_DUTY_RANGE_NEG = 3'd1,
        REG_DUTY_RANGE_POS = 3'd2,
        REG_DUTY_FLOOR     = 3'd3,
        REG_DUTY_CEILING   = 3'd4,
        REG_STEP_FORWARD   = 3'd5,
        REG_STEP_REVERSE   = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SET_SPEED = 3'd1,
        OP_BRAKE     = 3'd2,
        OP_STEP_UP   = 3'd3,
        OP_STEP_DOWN = 3'd4,
        OP_PAUSE     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        HD_UNDEF = 2'd0,
        HD_FWD   = 2'd1,
        HD_REV   = 2'd2
    } t_heading;

    typedef enum logic [2:0] {
        PH_NORMAL      = 3'd0,
        PH_REV_PENDING = 3'd1,
        PH_REV_SET     = 3'd2,
        PH_NEUTRAL_SET = 3'd3,
        PH_FIN_BRAKE   = 3'd4
    } t_phase;

    // What the sequencer hands to the duty pipeline for one command.
    typedef struct packed {
        logic                  chg;
        logic                  neg;
        logic                  zero;
        logic [MAG_WIDTH-1:0]  mag;
        logic signed [7:0]     speed;
        t_heading              heading;
        t_phase                phase;
        logic                  brake;
        logic signed [7:0]     prior;
    } t_seq_word;

endpackage

FILE: hw/rtl/esc_srs_cfg.sv
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port, plus the duty ranges split by 100.
// Depends on esc_srs_pkg.
module esc_srs_cfg
    import esc_srs_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [DUTY_WIDTH-1:0]     o_neutral,
    output logic [DUTY_WIDTH-1:0]     o_floor,
    output logic [DUTY_WIDTH-1:0]     o_ceiling,
    output logic [DUTY_WIDTH-1:0]     o_quot_neg,
    output logic [DUTY_WIDTH-1:0]     o_quot_pos,
    output logic [MAG_WIDTH-1:0]      o_rem_neg,
    output logic [MAG_WIDTH-1:0]      o_rem_pos,
    output logic [STEP_WIDTH-1:0]     o_step_fwd,
    output logic [STEP_WIDTH-1:0]     o_step_rev
);

    logic [DUTY_WIDTH-1:0] r_neutral, r_range_neg, r_range_pos, r_floor, r_ceiling;
    logic [STEP_WIDTH-1:0] r_step_fwd, r_step_rev;
    logic [DUTY_WIDTH-1:0] r_quot_neg, r_quot_pos;
    logic                  wr_en;
    t_reg_idx              idx;
    logic [63:0]           prod_neg, prod_pos;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[CFG_ADDR_WIDTH-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neutral   <= '0;
            r_range_neg <= '0;
            r_range_pos <= '0;
            r_floor     <= '0;
            r_ceiling   <= DUTY_WIDTH'(DUTY_CEIL_RESET);
            r_step_fwd  <= STEP_RESET;
            r_step_rev  <= STEP_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_DUTY_NEUTRAL:   r_neutral   <= pwdata[DUTY_WIDTH-1:0];
                REG_DUTY_RANGE_NEG: r_range_neg <= pwdata[DUTY_WIDTH-1:0];
                REG_DUTY_RANGE_POS: r_range_pos <= pwdata[DUTY_WIDTH-1:0];
                REG_DUTY_FLOOR:     r_floor     <= pwdata[DUTY_WIDTH-1:0];
                REG_DUTY_CEILING:   r_ceiling   <= pwdata[DUTY_WIDTH-1:0];
                REG_STEP_FORWARD:   r_step_fwd  <= pwdata[STEP_WIDTH-1:0];
                REG_STEP_REVERSE:   r_step_rev  <= pwdata[STEP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Range = 100 * quotient + remainder. The quotient is registered from the range register,
    // and the remainder is formed from it without a further register.
    assign prod_neg = 64'(32'(r_range_neg)) * 64'(RECIP_100);
    assign prod_pos = 64'(32'(r_range_pos)) * 64'(RECIP_100);

    always_ff @(posedge i_clk) begin
        r_quot_neg <= DUTY_WIDTH'(prod_neg >> RECIP_100_SHIFT);
        r_quot_pos <= DUTY_WIDTH'(prod_pos >> RECIP_100_SHIFT);
    end

    always_comb begin
        unique case (idx)
            REG_DUTY_NEUTRAL:   prdata = 32'(r_neutral);
            REG_DUTY_RANGE_NEG: prdata = 32'(r_range_neg);
            REG_DUTY_RANGE_POS: prdata = 32'(r_range_pos);
            REG_DUTY_FLOOR:     prdata = 32'(r_floor);
            REG_DUTY_CEILING:   prdata = 32'(r_ceiling);
            REG_STEP_FORWARD:   prdata = 32'(r_step_fwd);
            REG_STEP_REVERSE:   prdata = 32'(r_step_rev);
            default:            prdata = '0;
        endcase
    end

    assign o_neutral  = r_neutral;
    assign o_floor    = r_floor;
    assign o_ceiling  = r_ceiling;
    assign o_quot_neg = r_quot_neg;
    assign o_quot_pos = r_quot_pos;
    assign o_rem_neg  = MAG_WIDTH'(32'(r_range_neg) - 32'(r_quot_neg) * 32'd100);
    assign o_rem_pos  = MAG_WIDTH'(32'(r_range_pos) - 32'(r_quot_pos) * 32'd100);
    assign o_step_fwd = r_step_fwd;
    assign o_step_rev = r_step_rev;

endmodule

FILE: hw/rtl/esc_srs_seq.sv
`timescale 1ns / 1ps
// Command input register and the speed, heading, phase and brake sequencer.
// Depends on esc_srs_pkg.
module esc_srs_seq
    import esc_srs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_operation,
    input  logic signed [7:0]     i_speed_value,
    input  logic [STEP_WIDTH-1:0] i_step_fwd,
    input  logic [STEP_WIDTH-1:0] i_step_rev,
    output logic                  o_word_valid,
    input  logic                  i_word_ready,
    output t_seq_word             o_word
);

    logic                            r_in_valid;
    logic [2:0]                      r_op;
    logic signed [7:0]               r_sv;
    logic signed [7:0]               r_speed;
    t_heading                        r_heading;
    t_phase                          r_phase;
    logic                            r_brake;
    logic                            r_word_valid;
    t_seq_word                       r_word;

    logic signed [7:0]               n_speed;
    t_heading                        n_heading;
    t_phase                          n_phase;
    logic                            n_brake;
    t_seq_word                       n_word;

    logic                            load_word, load_in, step_now;
    logic                            apply, chg, hd_force;
    t_heading                        hd_val;
    logic signed [SPD_EXT_WIDTH-1:0] req, spd_ext, step_sel, nxt_dn;
    logic signed [7:0]               sat_s, abs_s;

    function automatic logic signed [7:0] sat_speed(input logic signed [SPD_EXT_WIDTH-1:0] s);
        logic signed [7:0] res;
        if (s < SPEED_MIN) begin
            res = 8'(SPEED_MIN);
        end else if (s > SPEED_MAX) begin
            res = 8'(SPEED_MAX);
        end else begin
            res = 8'(s);
        end
        return res;
    endfunction

    assign load_word  = !r_word_valid || i_word_ready;
    assign load_in    = !r_in_valid || load_word;
    assign o_in_ready = load_in;
    assign step_now   = load_word && r_in_valid;

    assign spd_ext  = $signed({{(SPD_EXT_WIDTH-8){r_speed[7]}}, r_speed});
    assign step_sel = (r_speed >= 0) ? $signed({3'b000, i_step_fwd})
                                     : $signed({3'b000, i_step_rev});
    assign nxt_dn   = spd_ext - step_sel;

    always_comb begin
        n_heading = r_heading;
        n_phase   = r_phase;
        n_brake   = r_brake;
        req       = SPEED_ZERO;
        apply     = 1'b0;
        hd_force  = 1'b0;
        hd_val    = r_heading;
        case (t_op'(r_op))
            OP_TICK: begin
                unique case (r_phase)
                    PH_NORMAL: begin
                        if (r_brake && r_heading == HD_REV) begin
                            apply    = 1'b1;
                            req      = BRAKE_FWD_SPEED;
                            n_phase  = PH_FIN_BRAKE;
                            n_brake  = 1'b0;
                            hd_force = 1'b1;
                            hd_val   = HD_FWD;
                        end else if (r_speed > 0) begin
                            apply = 1'b1;
                            req   = spd_ext - 10'sd1;
                        end else if (r_speed < 0) begin
                            apply = 1'b1;
                            req   = spd_ext + 10'sd1;
                        end
                    end
                    PH_REV_PENDING: begin
                        apply   = 1'b1;
                        req     = REV_PROBE_SPEED;
                        n_phase = PH_REV_SET;
                    end
                    PH_REV_SET: begin
                        apply   = 1'b1;
                        req     = SPEED_ZERO;
                        n_phase = PH_NEUTRAL_SET;
                    end
                    PH_NEUTRAL_SET: begin
                        apply = 1'b1;
                        if (r_brake) begin
                            req      = SPEED_MIN;
                            n_phase  = PH_FIN_BRAKE;
                            n_brake  = 1'b0;
                            hd_force = 1'b1;
                            hd_val   = HD_REV;
                        end else begin
                            req     = -$signed({3'b000, i_step_rev});
                            n_phase = PH_NORMAL;
                        end
                    end
                    PH_FIN_BRAKE: begin
                        apply   = 1'b1;
                        req     = SPEED_ZERO;
                        n_phase = PH_NORMAL;
                    end
                    default: ;
                endcase
            end
            OP_SET_SPEED: begin
                apply = 1'b1;
                req   = $signed({{(SPD_EXT_WIDTH-8){r_sv[7]}}, r_sv});
            end
            OP_BRAKE: begin
                n_brake = 1'b1;
                if (r_heading == HD_FWD) begin
                    n_phase = PH_REV_PENDING;
                end
            end
            OP_STEP_UP: begin
                n_brake = 1'b0;
                apply   = 1'b1;
                req     = spd_ext + step_sel;
            end
            OP_STEP_DOWN: begin
                n_brake = 1'b0;
                if (r_phase == PH_NORMAL) begin
                    // Stepping down through zero while heading forward starts the
                    // reverse sequence instead of changing the speed.
                    if (r_speed >= 0 && nxt_dn < 0 && r_heading == HD_FWD) begin
                        hd_force = 1'b1;
                        hd_val   = HD_REV;
                        n_phase  = PH_REV_PENDING;
                    end else begin
                        apply = 1'b1;
                        req   = nxt_dn;
                    end
                end
            end
            OP_PAUSE: begin
                apply = 1'b1;
                req   = SPEED_ZERO;
            end
            default: ;
        endcase

        sat_s   = sat_speed(req);
        chg     = apply && (sat_s != r_speed);
        n_speed = r_speed;
        if (chg) begin
            n_speed = sat_s;
            if (sat_s > 0) begin
                n_heading = HD_FWD;
            end
        end
        if (hd_force) begin
            n_heading = hd_val;
        end

        abs_s          = (sat_s < 0) ? -sat_s : sat_s;
        n_word.chg     = chg;
        n_word.neg     = sat_s < 0;
        n_word.zero    = sat_s == 0;
        n_word.mag     = abs_s[MAG_WIDTH-1:0];
        n_word.speed   = n_speed;
        n_word.heading = n_heading;
        n_word.phase   = n_phase;
        n_word.brake   = n_brake;
        n_word.prior   = r_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_word_valid <= 1'b0;
            r_speed      <= '0;
            r_heading    <= HD_UNDEF;
            r_phase      <= PH_NORMAL;
            r_brake      <= 1'b0;
        end else begin
            if (load_in) begin
                r_in_valid <= i_in_valid;
                r_op       <= i_operation;
                r_sv       <= i_speed_value;
            end
            if (load_word) begin
                r_word_valid <= r_in_valid;
                r_word       <= n_word;
            end
            if (step_now) begin
                r_speed   <= n_speed;
                r_heading <= n_heading;
                r_phase   <= n_phase;
                r_brake   <= n_brake;
            end
        end
    end

    assign o_word_valid = r_word_valid;
    assign o_word       = r_word;

endmodule

FILE: hw/rtl/esc_srs_duty.sv
`timescale 1ns / 1ps
// Duty pipeline: scale the speed by the range, divide by 100, clamp, and hold the result word.
// Depends on esc_srs_pkg.
module esc_srs_duty
    import esc_srs_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_word_valid,
    output logic                  o_word_ready,
    input  t_seq_word             i_word,
    input  logic [DUTY_WIDTH-1:0] i_neutral,
    input  logic [DUTY_WIDTH-1:0] i_floor,
    input  logic [DUTY_WIDTH-1:0] i_ceiling,
    input  logic [DUTY_WIDTH-1:0] i_quot_neg,
    input  logic [DUTY_WIDTH-1:0] i_quot_pos,
    input  logic [MAG_WIDTH-1:0]  i_rem_neg,
    input  logic [MAG_WIDTH-1:0]  i_rem_pos,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DUTY_WIDTH-1:0] o_duty_count,
    output logic signed [7:0]     o_speed_now,
    output logic [1:0]            o_heading,
    output logic [2:0]            o_phase,
    output logic                  o_brake_flag,
    output logic signed [7:0]     o_prior_speed
);

    localparam int HI_WIDTH = DUTY_WIDTH + MAG_WIDTH;
    localparam int LO_WIDTH = 2 * MAG_WIDTH;
    localparam int LP_WIDTH = LO_WIDTH + 13;
    localparam int D_WIDTH  = DUTY_WIDTH + 2;

    logic                      r_v2, r_v3, r_vout;
    logic [HI_WIDTH-1:0]       r2_hi;
    logic [LO_WIDTH-1:0]       r2_lo;
    t_seq_word                 r2_word, r3_word, r_out_word;
    logic signed [D_WIDTH-1:0] r3_d;
    logic [DUTY_WIDTH-1:0]     r_duty;

    logic                      load_out, load3, load2;
    logic [DUTY_WIDTH-1:0]     q_sel;
    logic [MAG_WIDTH-1:0]      rem_sel;
    logic [LP_WIDTH-1:0]       lo_prod;
    logic [MAG_WIDTH-1:0]      lo_q, lo_r;
    logic [LO_WIDTH-1:0]       lo_c;
    logic [HI_WIDTH-1:0]       q_sum;
    logic [DUTY_WIDTH-1:0]     q;
    logic signed [D_WIDTH-1:0] n_ext, q_ext, fl_ext, cl_ext, n_d, d_fl, d_cl;

    assign load_out     = !r_vout || i_out_ready;
    assign load3        = !r_v3 || load_out;
    assign load2        = !r_v2 || load3;
    assign o_word_ready = load2;

    // Stage two: quotient and remainder parts of range times magnitude.
    assign q_sel   = i_word.neg ? i_quot_neg : i_quot_pos;
    assign rem_sel = i_word.neg ? i_rem_neg : i_rem_pos;

    // Stage three: finish the divide by 100 and form the truncated duty.
    assign lo_prod = LP_WIDTH'(r2_lo) * LP_WIDTH'(RECIP_100_SMALL);
    assign lo_q    = MAG_WIDTH'(lo_prod >> RECIP_100_SMALL_SHIFT);
    assign lo_c    = LO_WIDTH'(lo_q) * LO_WIDTH'(100);
    assign lo_r    = r2_lo[MAG_WIDTH-1:0] - lo_c[MAG_WIDTH-1:0];
    assign q_sum   = r2_hi + HI_WIDTH'(lo_q);
    assign q       = q_sum[DUTY_WIDTH-1:0];
    assign n_ext   = $signed({2'b00, i_neutral});
    assign q_ext   = $signed({2'b00, q});

    always_comb begin
        if (r2_word.zero) begin
            n_d = n_ext;
        end else if (!r2_word.neg) begin
            n_d = n_ext + q_ext;
        end else if (i_neutral > q && lo_r != '0) begin
            // A positive numerator with a remainder truncates one step lower.
            n_d = n_ext - q_ext - D_WIDTH'(1);
        end else begin
            n_d = n_ext - q_ext;
        end
    end

    // Output stage: floor first, then the ceiling, which wins if they cross.
    assign fl_ext = $signed({2'b00, i_floor});
    assign cl_ext = $signed({2'b00, i_ceiling});
    assign d_fl   = (r3_d < fl_ext) ? fl_ext : r3_d;
    assign d_cl   = (d_fl >= cl_ext) ? cl_ext : d_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vout <= 1'b0;
            r_duty <= '0;
        end else begin
            if (load2) begin
                r_v2    <= i_word_valid;
                r2_word <= i_word;
                r2_hi   <= HI_WIDTH'(q_sel) * HI_WIDTH'(i_word.mag);
                r2_lo   <= LO_WIDTH'(rem_sel) * LO_WIDTH'(i_word.mag);
            end
            if (load3) begin
                r_v3    <= r_v2;
                r3_word <= r2_word;
                r3_d    <= n_d;
            end
            if (load_out) begin
                r_vout     <= r_v3;
                r_out_word <= r3_word;
                if (r_v3 && r3_word.chg) begin
                    r_duty <= d_cl[DUTY_WIDTH-1:0];
                end
            end
        end
    end

    assign o_out_valid   = r_vout;
    assign o_duty_count  = r_duty;
    assign o_speed_now   = r_out_word.speed;
    assign o_heading     = r_out_word.heading;
    assign o_phase       = r_out_word.phase;
    assign o_brake_flag  = r_out_word.brake;
    assign o_prior_speed = r_out_word.prior;

endmodule

FILE: hw/rtl/esc_speed_reverse_sequencer.sv
`timescale 1ns / 1ps
// Top level of the ESC speed and reverse sequencer: config port, sequencer and duty pipeline.
// Depends on esc_srs_pkg, esc_srs_cfg, esc_srs_seq and esc_srs_duty.
//
//   Channel   Direction  Handshake             Payload
//   command   in         i_in_valid/o_in_ready  i_operation, i_speed_value
//   result    out        o_out_valid/i_out_ready o_duty_count, o_speed_now, o_heading,
//                                               o_phase, o_brake_flag, o_prior_speed
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// A command word is accepted every cycle while o_in_ready is high; the accepting edge loads
// the first of five registers (input register, sequencer stage, two duty arithmetic stages,
// output register), and its result word is valid once it reaches the output register.
// The sequencer state is registered from the input register, so back-to-back commands see each other.
// The duty pipeline takes the ranges pre-split by 100, whose registered quotients settle after
// a write before any command accepted at the writing edge reaches the duty stages.
// Reset is synchronous and active low; it clears the sequencer state, the duty count to zero
// and all pipeline valids. A stalled result holds each stage behind it up to the first empty one,
// which still fills; o_in_ready drops only when the pipeline is full behind a stalled output.
module esc_speed_reverse_sequencer
    import esc_srs_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_operation,
    input  logic signed [7:0]         i_speed_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [DUTY_WIDTH-1:0]     o_duty_count,
    output logic signed [7:0]         o_speed_now,
    output logic [1:0]                o_heading,
    output logic [2:0]                o_phase,
    output logic                      o_brake_flag,
    output logic signed [7:0]         o_prior_speed
);

    logic [DUTY_WIDTH-1:0] neutral, floor_v, ceiling, quot_neg, quot_pos;
    logic [MAG_WIDTH-1:0]  rem_neg, rem_pos;
    logic [STEP_WIDTH-1:0] step_fwd, step_rev;
    logic                  word_valid, word_ready;
    t_seq_word             word;

    // Register file; the user changes configuration only with no command in flight; not enforced.
    esc_srs_cfg #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_neutral  (neutral),
        .o_floor    (floor_v),
        .o_ceiling  (ceiling),
        .o_quot_neg (quot_neg),
        .o_quot_pos (quot_pos),
        .o_rem_neg  (rem_neg),
        .o_rem_pos  (rem_pos),
        .o_step_fwd (step_fwd),
        .o_step_rev (step_rev)
    );

    // The sequencer decides the new speed and flags whether the duty must be recomputed.
    esc_srs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_speed_value (i_speed_value),
        .i_step_fwd    (step_fwd),
        .i_step_rev    (step_rev),
        .o_word_valid  (word_valid),
        .i_word_ready  (word_ready),
        .o_word        (word)
    );

    // The duty count never feeds back into the sequencer, so it can trail in a pipeline.
    esc_srs_duty #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_duty (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word_valid  (word_valid),
        .o_word_ready  (word_ready),
        .i_word        (word),
        .i_neutral     (neutral),
        .i_floor       (floor_v),
        .i_ceiling     (ceiling),
        .i_quot_neg    (quot_neg),
        .i_quot_pos    (quot_pos),
        .i_rem_neg     (rem_neg),
        .i_rem_pos     (rem_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_duty_count  (o_duty_count),
        .o_speed_now   (o_speed_now),
        .o_heading     (o_heading),
        .o_phase       (o_phase),
        .o_brake_flag  (o_brake_flag),
        .o_prior_speed (o_prior_speed)
    );

endmodule

FILE: hw/rtl/esc_srs_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the ESC speed and reverse sequencer, bound to the top level.
// Depends on esc_srs_pkg and esc_speed_reverse_sequencer.
module esc_srs_checker
    import esc_srs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic signed [7:0] o_speed_now,
    input logic [1:0]        o_heading,
    input logic signed [7:0] o_prior_speed
);

    // A draining output leaves room for a new command word in the same cycle.
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("command not accepted while output drains");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed_now >= -8'sd100 && o_speed_now <= 8'sd100))
        else $error("speed out of saturation range");

    a_prior_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_prior_speed >= -8'sd100 && o_prior_speed <= 8'sd100))
        else $error("prior speed out of saturation range");

    // Any positive speed has set a heading, and a heading never returns to undefined.
    a_heading_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speed_now > 8'sd0) |-> (o_heading != HD_UNDEF))
        else $error("positive speed with undefined heading");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_speed_now) && $stable(o_prior_speed)))
        else $error("stalled result word changed");

endmodule

bind esc_speed_reverse_sequencer esc_srs_checker u_esc_srs_checker (.*);

FILE: bench/esc_speed_reverse_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for esc_speed_reverse_sequencer: a directed command table and then
// randomized command phases under several register settings, with every result word checked.
// Depends on esc_srs_pkg and the esc_speed_reverse_sequencer RTL.
module esc_speed_reverse_sequencer_test;
    import esc_srs_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 7;
    // Cycles with no accepted word on any channel before the run is declared hung.
    localparam int STALL_LIMIT     = 1000;
    // Extra cycles after the last expected word that let stray words from the pipeline show up.
    localparam int QUIET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 7;
    localparam int WORDS_PER_PHASE = 205;

    // Operation codes that the block must treat as no-ops.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // One result word as the block reports it.
    typedef struct packed {
        logic [15:0]       duty;
        logic signed [7:0] speed;
        t_heading          heading;
        t_phase            phase;
        logic              brake;
        logic signed [7:0] prior;
    } motor_word_t;

    // One row of the directed command table. Rows with typed set carry a hand-written
    // result; all other rows are checked against the motor model below.
    typedef struct packed {
        logic [2:0]        op;
        logic signed [7:0] value;
        logic              typed;
        motor_word_t       want;
    } plan_row_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [2:0]                i_operation = '0;
    logic signed [7:0]         i_speed_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [15:0]               o_duty_count;
    logic signed [7:0]         o_speed_now;
    logic [1:0]                o_heading;
    logic [2:0]                o_phase;
    logic                      o_brake_flag;
    logic signed [7:0]         o_prior_speed;

    // Motor model state, a copy of what the block should hold after every accepted word.
    int          motor_speed   = 0;
    t_heading    motor_heading = HD_UNDEF;
    t_phase      seq_phase     = PH_NORMAL;
    logic        brake_pending = 1'b0;
    logic [15:0] duty_now      = '0;

    // Register copies, at their reset values until the first write.
    longint cfg_neutral   = 0;
    longint cfg_range_neg = 0;
    longint cfg_range_pos = 0;
    longint cfg_floor     = 0;
    longint cfg_ceiling   = longint'(DUTY_CEIL_RESET);
    int     cfg_step_fwd  = int'(STEP_RESET);
    int     cfg_step_rev  = int'(STEP_RESET);

    motor_word_t pending_words[$];   // expected result words, oldest first
    plan_row_t   plan[$];            // directed command table
    int          mismatches  = 0;
    int          idle_cycles = 0;
    // When set, neither side inserts gaps, so words move back to back.
    bit          calm = 1'b0;

    esc_speed_reverse_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_speed_value (i_speed_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_duty_count  (o_duty_count),
        .o_speed_now   (o_speed_now),
        .o_heading     (o_heading),
        .o_phase       (o_phase),
        .o_brake_flag  (o_brake_flag),
        .o_prior_speed (o_prior_speed)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------------------
    // Motor model
    // ------------------------------------------------------------------------------------

    function automatic int clamp_speed(int s);
        if (s < int'(SPEED_MIN)) return int'(SPEED_MIN);
        if (s > int'(SPEED_MAX)) return int'(SPEED_MAX);
        return s;
    endfunction

    // Moves to a new speed. The duty count is only recomputed when the saturated speed
    // actually differs from the current one, so a register change alone never moves it.
    function automatic void move_to_speed(int request);
        int     target;
        longint level;
        target = clamp_speed(request);
        if (target == motor_speed) return;
        if (target < 0) begin
            level = (cfg_neutral * 100 + cfg_range_neg * target) / 100;
        end else if (target > 0) begin
            level = (cfg_neutral * 100 + cfg_range_pos * target) / 100;
            motor_heading = HD_FWD;
        end else begin
            level = cfg_neutral;
        end
        // Signed division above truncates toward zero. The ceiling is applied last, so it
        // wins when the floor lies above it.
        if (level < cfg_floor) level = cfg_floor;
        if (level >= cfg_ceiling) level = cfg_ceiling;
        duty_now    = level[15:0];
        motor_speed = target;
    endfunction

    // Applies one command to the model and returns the word the block should report.
    function automatic motor_word_t predict_command(logic [2:0] op, logic signed [7:0] value);
        motor_word_t word;
        int          start_speed;
        int          lowered;
        start_speed = motor_speed;
        case (op)
            OP_TICK: begin
                case (seq_phase)
                    PH_NORMAL: begin
                        // A brake requested while heading in reverse kicks forward first.
                        if (brake_pending && motor_heading == HD_REV) begin
                            move_to_speed(int'(BRAKE_FWD_SPEED));
                            seq_phase     = PH_FIN_BRAKE;
                            brake_pending = 1'b0;
                            motor_heading = HD_FWD;
                        end else if (motor_speed > 0) begin
                            move_to_speed(motor_speed - 1);
                        end else if (motor_speed < 0) begin
                            move_to_speed(motor_speed + 1);
                        end
                    end
                    PH_REV_PENDING: begin
                        move_to_speed(int'(REV_PROBE_SPEED));
                        seq_phase = PH_REV_SET;
                    end
                    PH_REV_SET: begin
                        move_to_speed(int'(SPEED_ZERO));
                        seq_phase = PH_NEUTRAL_SET;
                    end
                    PH_NEUTRAL_SET: begin
                        if (brake_pending) begin
                            move_to_speed(int'(SPEED_MIN));
                            seq_phase     = PH_FIN_BRAKE;
                            brake_pending = 1'b0;
                            motor_heading = HD_REV;
                        end else begin
                            move_to_speed(-cfg_step_rev);
                            seq_phase = PH_NORMAL;
                        end
                    end
                    PH_FIN_BRAKE: begin
                        seq_phase = PH_NORMAL;
                        move_to_speed(int'(SPEED_ZERO));
                    end
                    default: ;
                endcase
            end
            OP_SET_SPEED: move_to_speed(int'(value));
            OP_BRAKE: begin
                brake_pending = 1'b1;
                if (motor_heading == HD_FWD) seq_phase = PH_REV_PENDING;
            end
            OP_STEP_UP: begin
                brake_pending = 1'b0;
                move_to_speed(motor_speed + (motor_speed >= 0 ? cfg_step_fwd : cfg_step_rev));
            end
            OP_STEP_DOWN: begin
                brake_pending = 1'b0;
                lowered = motor_speed - (motor_speed >= 0 ? cfg_step_fwd : cfg_step_rev);
                // Stepping through zero while heading forward starts the reverse sequence
                // instead of changing speed; outside the normal phase nothing moves.
                if (seq_phase == PH_NORMAL) begin
                    if (motor_speed >= 0 && lowered < 0 && motor_heading == HD_FWD) begin
                        motor_heading = HD_REV;
                        seq_phase     = PH_REV_PENDING;
                    end else begin
                        move_to_speed(lowered);
                    end
                end
            end
            OP_PAUSE: move_to_speed(int'(SPEED_ZERO));
            default: ;
        endcase
        word.duty    = duty_now;
        word.speed   = motor_speed[7:0];
        word.heading = motor_heading;
        word.phase   = seq_phase;
        word.brake   = brake_pending;
        word.prior   = start_speed[7:0];
        return word;
    endfunction

    function automatic motor_word_t make_word(logic [15:0] duty, logic signed [7:0] speed,
                                              t_heading heading, t_phase phase,
                                              logic brake, logic signed [7:0] prior);
        motor_word_t word;
        word.duty    = duty;
        word.speed   = speed;
        word.heading = heading;
        word.phase   = phase;
        word.brake   = brake;
        word.prior   = prior;
        return word;
    endfunction

    function automatic void add_row(logic [2:0] op, logic signed [7:0] value,
                                    logic typed = 1'b0, motor_word_t want = '0);
        plan_row_t row;
        row.op    = op;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic void compare_field(string field, int expected, int actual);
        if (expected != actual) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------------------

    // Presents one command word, optionally after a gap, and holds it until accepted.
    // The model is advanced at the accepting edge, so expectations follow acceptance order.
    task automatic send_command(input logic [2:0] op, input logic signed [7:0] value,
                                input logic typed, input motor_word_t want);
        int          gap;
        motor_word_t predicted;
        gap = calm ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_speed_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_command(op, value);
        pending_words.push_back(typed ? want : predicted);
    endtask

    // One register transfer: setup cycle, then access cycle until pready. A write updates
    // the register copies; a read checks prdata against the given value.
    task automatic access_register(input logic is_write, input t_reg_idx idx,
                                   input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!is_write) begin
            compare_field("register readback", int'(value), int'(prdata));
        end else begin
            case (idx)
                REG_DUTY_NEUTRAL:   cfg_neutral   = longint'(value[15:0]);
                REG_DUTY_RANGE_NEG: cfg_range_neg = longint'(value[15:0]);
                REG_DUTY_RANGE_POS: cfg_range_pos = longint'(value[15:0]);
                REG_DUTY_FLOOR:     cfg_floor     = longint'(value[15:0]);
                REG_DUTY_CEILING:   cfg_ceiling   = longint'(value[15:0]);
                REG_STEP_FORWARD:   cfg_step_fwd  = int'(value[6:0]);
                REG_STEP_REVERSE:   cfg_step_rev  = int'(value[6:0]);
                default: ;
            endcase
        end
    endtask

    // Writes all seven registers and reads them back. The readback also gives the block's
    // registered pre-divided ranges time to settle after a write.
    task automatic apply_settings(input logic [15:0] neutral, input logic [15:0] span_neg,
                                  input logic [15:0] span_pos, input logic [15:0] lowest,
                                  input logic [15:0] highest, input logic [6:0] step_fwd,
                                  input logic [6:0] step_rev);
        logic [31:0] values [0:6];
        values[0] = 32'(neutral);
        values[1] = 32'(span_neg);
        values[2] = 32'(span_pos);
        values[3] = 32'(lowest);
        values[4] = 32'(highest);
        values[5] = 32'(step_fwd);
        values[6] = 32'(step_rev);
        for (int r = 0; r < 7; r++) access_register(1'b1, t_reg_idx'(r), values[r]);
        for (int r = 0; r < 7; r++) access_register(1'b0, t_reg_idx'(r), values[r]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stops sending and waits until every expected word has come back, then keeps the
    // pipeline running empty so that any stray words still show up.
    task automatic wait_for_quiet;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------------------
    // Result side: random stalls on ready, and the checker
    // ------------------------------------------------------------------------------------

    initial begin : result_sink
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    // Every accepted result word is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin
        motor_word_t oldest;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: result word with none expected, duty %0d speed %0d",
                         $time, o_duty_count, o_speed_now);
                mismatches++;
            end else begin
                oldest = pending_words.pop_front();
                compare_field("duty_count", int'(oldest.duty), int'(o_duty_count));
                compare_field("speed_now", int'($signed(oldest.speed)), int'(o_speed_now));
                compare_field("heading", int'(oldest.heading), int'(o_heading));
                compare_field("phase", int'(oldest.phase), int'(o_phase));
                compare_field("brake_flag", int'(oldest.brake), int'(o_brake_flag));
                compare_field("prior_speed", int'($signed(oldest.prior)),
                              int'(o_prior_speed));
            end
        end
    end

    // Watchdog: any accepted word on either channel or any register transfer counts as
    // progress. A hung handshake ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------------------

    initial begin : stimulus
        logic [2:0]        op;
        logic signed [7:0] value;
        int                roll;
        logic [15:0]       lowest;
        logic [15:0]       highest;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Floor and ceiling both bite at full speed in this setting: full forward would
        // give 65000 and full reverse 0.
        apply_settings(16'd30000, 16'd30000, 16'd35000, 16'd5000, 16'd60000, 7'd10, 7'd10);

        // A tick at rest changes nothing, and the duty count keeps its reset value even
        // though the neutral register now holds something else.
        add_row(OP_TICK, 8'sd0, 1'b1, make_word(16'd0, 8'sd0, HD_UNDEF, PH_NORMAL, 1'b0, 8'sd0));
        // Set speed saturates to the limits; the extremes hit the ceiling and the floor.
        add_row(OP_SET_SPEED, 8'sd127, 1'b1,
                make_word(16'd60000, 8'sd100, HD_FWD, PH_NORMAL, 1'b0, 8'sd0));
        // A negative set speed leaves the heading alone.
        add_row(OP_SET_SPEED, -8'sd128, 1'b1,
                make_word(16'd5000, -8'sd100, HD_FWD, PH_NORMAL, 1'b0, 8'sd100));
        add_row(OP_SET_SPEED, 8'sd0, 1'b1,
                make_word(16'd30000, 8'sd0, HD_FWD, PH_NORMAL, 1'b0, -8'sd100));
        add_row(OP_STEP_UP, 8'sd0);
        add_row(OP_STEP_DOWN, 8'sd0);
        // Stepping below zero while heading forward arms the reverse sequence.
        add_row(OP_STEP_DOWN, 8'sd0);
        // Outside the normal phase a step down only clears the brake flag.
        add_row(OP_STEP_DOWN, 8'sd0);
        // Reverse sequence: probe speed, neutral, then the reverse step speed.
        add_row(OP_TICK, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        // Step up from a negative speed uses the reverse step size.
        add_row(OP_STEP_UP, 8'sd0);
        // Heading is reverse now, so stepping below zero moves the speed directly.
        add_row(OP_STEP_DOWN, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        // Brake while heading in reverse: the next tick kicks forward, the tick after it finishes braking.
        add_row(OP_BRAKE, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        // Brake while heading forward runs the whole sequence through full reverse back to zero.
        add_row(OP_SET_SPEED, 8'sd100);
        add_row(OP_BRAKE, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        add_row(OP_TICK, 8'sd0);
        // Pause reports the speed held before it.
        add_row(OP_SET_SPEED, 8'sd55);
        add_row(OP_PAUSE, -8'sd1);
        // Unused operation codes change nothing.
        add_row(OP_SPARE_6, 8'sd127);
        add_row(OP_SPARE_7, -8'sd1);

        foreach (plan[i]) send_command(plan[i].op, plan[i].value, plan[i].typed, plan[i].want);

        // Random phases, each under its own register setting. The model state carries
        // over from one phase to the next, just as the block's does.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_for_quiet;
            case (p)
                0: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 7'd0);
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  7'd127, 7'd127);
                // Full spans around a high neutral: reverse goes below zero, forward
                // beyond the duty width.
                2: apply_settings(16'd40000, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF,
                                  7'd100, 7'd100);
                // Floor above the ceiling.
                3: apply_settings(16'd30000, 16'd20000, 16'd20000, 16'd50000, 16'd10000,
                                  7'd7, 7'd3);
                default: begin
                    lowest  = (p == 6) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 30000));
                    highest = (p == 6) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(35000, 65535));
                    apply_settings(16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)), lowest, highest,
                                   7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                end
            endcase
            calm = (p == 1 || p == 4);

            repeat (WORDS_PER_PHASE) begin
                // Ticks dominate so that the reverse and brake sequences run to the end.
                roll = $urandom_range(0, 99);
                if (roll < 38)      op = OP_TICK;
                else if (roll < 52) op = OP_SET_SPEED;
                else if (roll < 62) op = OP_BRAKE;
                else if (roll < 74) op = OP_STEP_UP;
                else if (roll < 88) op = OP_STEP_DOWN;
                else if (roll < 94) op = OP_PAUSE;
                else if (roll < 97) op = OP_SPARE_6;
                else                op = OP_SPARE_7;

                // Speed requests mix the full range, small values and the saturation edges.
                case ($urandom_range(0, 3))
                    0, 1: value = 8'($urandom_range(0, 255));
                    2:    value = 8'($signed($urandom_range(0, 60)) - 30);
                    default: begin
                        case ($urandom_range(0, 7))
                            0: value = -8'sd128;
                            1: value = 8'sd127;
                            2: value = 8'sd100;
                            3: value = -8'sd100;
                            4: value = 8'sd101;
                            5: value = -8'sd101;
                            6: value = 8'sd0;
                            default: value = -8'sd1;
                        endcase
                    end
                endcase
                send_command(op, value, 1'b0, '0);
            end
        end

        calm = 1'b0;
        wait_for_quiet;
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
